### sv/sphere_cap_z_extent_scan_assert.svh
// assertion macros for the spot z-extent scan
`ifndef SPHERE_CAP_Z_EXTENT_SCAN_ASSERT_SVH
`define SPHERE_CAP_Z_EXTENT_SCAN_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define SCZ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scz assertion failed");

// next-cycle implication
`define SCZ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scz assertion failed");

`endif

### sv/scz_pkg.sv
// types and constants of the spot z-extent scan
`timescale 1ns / 1ps
package scz_pkg;
  localparam int unsigned CRD_W = 18;
  localparam int unsigned RAD_W = 17;
  localparam int unsigned IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_SPHERE_CX = 3'd0;
  localparam logic [IDX_W-1:0] REG_SPHERE_CY = 3'd1;
  localparam logic [IDX_W-1:0] REG_SPHERE_CZ = 3'd2;
  localparam logic [IDX_W-1:0] REG_SCAN_CZ   = 3'd3;
  localparam logic [IDX_W-1:0] REG_RADIUS    = 3'd4;
  localparam logic [IDX_W-1:0] REG_STEP      = 3'd5;

  localparam logic [RAD_W-1:0] STEP_RESET = 17'd655;

  typedef struct packed {
    logic signed [CRD_W-1:0] sphere_center_x;
    logic signed [CRD_W-1:0] sphere_center_y;
    logic signed [CRD_W-1:0] sphere_center_z;
    logic signed [CRD_W-1:0] scan_center_z;
    logic [RAD_W-1:0]        spot_radius;
    logic [RAD_W-1:0]        grid_step;
  } scz_cfg_t;
endpackage

### sv/scz_ifs.sv
// valid/ready channel interfaces of the spot z-extent scan
`timescale 1ns / 1ps
interface scz_cfg_if import scz_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [CRD_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface scz_in_if import scz_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [CRD_W-1:0] row_y;
  modport source (output valid, row_y, input ready);
  modport sink (input valid, row_y, output ready);
endinterface

interface scz_out_if import scz_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [CRD_W-1:0] z_low;
  logic signed [CRD_W-1:0] z_high;
  logic                    hit;
  modport source (output valid, z_low, z_high, hit, input ready);
  modport sink (input valid, z_low, z_high, hit, output ready);
endinterface

### sv/scz_cfg_regs.sv
// configuration register file
`timescale 1ns / 1ps
module scz_cfg_regs import scz_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [IDX_W-1:0] idx_i,
  input  logic [CRD_W-1:0] data_i,
  output scz_cfg_t         cfg_o
);
  scz_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{sphere_center_x: '0, sphere_center_y: '0, sphere_center_z: '0,
                 scan_center_z: '0, spot_radius: '0, grid_step: STEP_RESET};
    end else if (wr_i) begin
      unique case (idx_i)
        REG_SPHERE_CX: cfg_q.sphere_center_x <= data_i;
        REG_SPHERE_CY: cfg_q.sphere_center_y <= data_i;
        REG_SPHERE_CZ: cfg_q.sphere_center_z <= data_i;
        REG_SCAN_CZ:   cfg_q.scan_center_z   <= data_i;
        REG_RADIUS:    cfg_q.spot_radius     <= data_i[RAD_W-1:0];
        REG_STEP:      cfg_q.grid_step       <= data_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;
endmodule

### sv/scz_sqrt.sv
// iterative integer square root, one result bit per cycle
`timescale 1ns / 1ps
module scz_sqrt #(
  parameter int unsigned PW = 42
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [PW-1:0] rad_i,
  output logic          done_o,
  output logic [PW-1:0] root_o
);
  logic [PW-1:0] rem_q, res_q, bit_q;
  logic          run_q, done_q;
  logic [PW-1:0] trial;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
      end else if (run_q && bit_q[0]) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rad_i;
      res_q <= '0;
      bit_q <= {2'b01, {(PW-2){1'b0}}};
    end else if (run_q) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q;
endmodule

### sv/sphere_cap_z_extent_scan.sv
// top level: row-wise z-extent scan of a spot on a unit sphere
//
//   channel   dir   payload                 handshake
//   cfg_if    in    index, data             valid/ready, always ready
//   in_if     in    row_y                   valid/ready
//   out_if    out   z_low, z_high, hit      valid/ready
//
// one row: the accept in IDLE, setup in RR, YY and DY, up to MAX_STEPS grid tests
// per scan direction plus one end check for a scan that runs out, and DONE to
// post the result; a test rejected by the disc range check ends in TEST, by the
// radius check in R2, otherwise it runs through the bit-serial square root and
// the single shared multiplier. reset clears the sequencer and loads register
// defaults; no clearing pass. a finished result waits in the output register
// while the next row starts; that row then holds in the done state until it frees.
`timescale 1ns / 1ps
module sphere_cap_z_extent_scan import scz_pkg::*; #(
  parameter int unsigned MAX_STEPS = 256,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  scz_cfg_if.sink    cfg_if,
  scz_in_if.sink     in_if,
  scz_out_if.source  out_if
);
  localparam int unsigned DW = (FRAC_BITS + 3 > 21) ? FRAC_BITS + 3 : 21;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned NW = $clog2(MAX_STEPS + 1);
  localparam logic signed [DW-1:0] ONE = {{(DW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [PW-1:0] ONE2 = {{(PW-1){1'b0}}, 1'b1} << (2 * FRAC_BITS);
  localparam logic [NW-1:0] NMAX = NW'(MAX_STEPS);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RR   = 4'd1;
  localparam logic [3:0] ST_YY   = 4'd2;
  localparam logic [3:0] ST_DY   = 4'd3;
  localparam logic [3:0] ST_TEST = 4'd4;
  localparam logic [3:0] ST_R2   = 4'd5;
  localparam logic [3:0] ST_SQRT = 4'd6;
  localparam logic [3:0] ST_DX   = 4'd7;
  localparam logic [3:0] ST_DZ   = 4'd8;
  localparam logic [3:0] ST_CMP  = 4'd9;
  localparam logic [3:0] ST_DONE = 4'd10;

  scz_cfg_t cfg;

  scz_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_if.valid),
    .idx_i  (cfg_if.index),
    .data_i (cfg_if.data),
    .cfg_o  (cfg)
  );
  assign cfg_if.ready = 1'b1;

  logic [3:0]           state_q, state_d;
  logic                 dir_q;
  logic [NW-1:0]        n_q;
  logic signed [DW-1:0] y_q, z_q, top_q, bot_q, zmax_q, zmin_q, x_q;
  logic                 got_max_q, got_min_q;
  logic [PW-1:0]        rr_q, yy_q, dyy_q, zz_q;
  logic [PW:0]          acc_q;
  logic                 out_valid_q, hit_q;
  logic [CRD_W-1:0]     z_low_q, z_high_q;

  logic signed [DW-1:0] cx, cy, cz, scz, rad, stp, mul_a;
  logic signed [PW-1:0] prod;
  logic [PW-1:0]        r2, root;
  logic                 sq_start, sq_done;
  logic                 scan_end, off_disc, pt_hit, in_range, slot_free, res_ok;

  assign cx  = DW'(cfg.sphere_center_x);
  assign cy  = DW'(cfg.sphere_center_y);
  assign cz  = DW'(cfg.sphere_center_z);
  assign scz = DW'(cfg.scan_center_z);
  assign rad = $signed({{(DW-RAD_W){1'b0}}, cfg.spot_radius});
  assign stp = $signed({{(DW-RAD_W){1'b0}}, cfg.grid_step});

  // the one shared multiplier, always a square
  always_comb begin
    unique case (state_q)
      ST_RR:   mul_a = rad;
      ST_YY:   mul_a = y_q;
      ST_DY:   mul_a = y_q - cy;
      ST_DX:   mul_a = x_q - cx;
      ST_DZ:   mul_a = z_q - cz;
      default: mul_a = z_q;
    endcase
  end
  assign prod = mul_a * mul_a;

  assign r2       = yy_q + zz_q;
  assign scan_end = (n_q == NMAX) || (dir_q ? !(z_q < top_q) : !(z_q > bot_q));
  assign off_disc = (y_q > ONE) || (y_q < -ONE) || (z_q > ONE) || (z_q < -ONE);
  assign pt_hit   = acc_q <= {1'b0, rr_q};
  assign in_range = (state_q == ST_R2) && !(r2 > ONE2);
  assign sq_start = in_range;
  assign slot_free = !out_valid_q || out_if.ready;
  assign res_ok   = got_max_q && got_min_q && !(zmin_q > ONE) && !(zmax_q > ONE);

  scz_sqrt #(.PW(PW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (ONE2 - r2),
    .done_o  (sq_done),
    .root_o  (root)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_if.valid) state_d = ST_RR;
      ST_RR:   state_d = ST_YY;
      ST_YY:   state_d = ST_DY;
      ST_DY:   state_d = ST_TEST;
      ST_TEST: begin
        if (scan_end) state_d = dir_q ? ST_DONE : ST_TEST;
        else if (!off_disc) state_d = ST_R2;
      end
      ST_R2:   state_d = in_range ? ST_SQRT : ST_TEST;
      ST_SQRT: if (sq_done) state_d = ST_DX;
      ST_DX:   state_d = ST_DZ;
      ST_DZ:   state_d = ST_CMP;
      ST_CMP:  state_d = (pt_hit && dir_q) ? ST_DONE : ST_TEST;
      ST_DONE: if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dir_q       <= 1'b0;
      n_q         <= '0;
      got_max_q   <= 1'b0;
      got_min_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_DONE) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          dir_q <= 1'b0;
          n_q   <= '0;
        end
        ST_TEST: begin
          if (scan_end) begin
            if (!dir_q) begin
              got_max_q <= 1'b0;
              dir_q     <= 1'b1;
              n_q       <= '0;
            end else begin
              got_min_q <= 1'b0;
            end
          end else if (off_disc) begin
            n_q <= n_q + 1'b1;
          end
        end
        ST_R2: if (!in_range) n_q <= n_q + 1'b1;
        ST_CMP: begin
          if (pt_hit) begin
            if (!dir_q) begin
              got_max_q <= 1'b1;
              dir_q     <= 1'b1;
              n_q       <= '0;
            end else begin
              got_min_q <= 1'b1;
            end
          end else begin
            n_q <= n_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        y_q   <= DW'(in_if.row_y);
        top_q <= scz + rad;
        bot_q <= scz - rad;
        z_q   <= scz + rad;
      end
      ST_RR:   rr_q  <= prod;
      ST_YY:   yy_q  <= prod;
      ST_DY:   dyy_q <= prod;
      ST_TEST: begin
        zz_q <= prod;
        if (scan_end) begin
          if (!dir_q) begin
            zmax_q <= z_q;
            z_q    <= bot_q;
          end else begin
            zmin_q <= z_q;
          end
        end else if (off_disc) begin
          z_q <= dir_q ? z_q + stp : z_q - stp;
        end
      end
      ST_R2: if (!in_range) z_q <= dir_q ? z_q + stp : z_q - stp;
      ST_SQRT: x_q <= root[DW-1:0];
      ST_DX:   acc_q <= {1'b0, dyy_q} + {1'b0, prod};
      ST_DZ:   acc_q <= acc_q + {1'b0, prod};
      ST_CMP: begin
        if (pt_hit) begin
          if (!dir_q) begin
            zmax_q <= z_q;
            z_q    <= bot_q;
          end else begin
            zmin_q <= z_q;
          end
        end else begin
          z_q <= dir_q ? z_q + stp : z_q - stp;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          hit_q    <= res_ok;
          z_low_q  <= res_ok ? zmin_q[CRD_W-1:0] : '0;
          z_high_q <= res_ok ? zmax_q[CRD_W-1:0] : '0;
        end
      end
      default: ;
    endcase
  end

  assign in_if.ready   = (state_q == ST_IDLE);
  assign out_if.valid  = out_valid_q;
  assign out_if.hit    = hit_q;
  assign out_if.z_low  = z_low_q;
  assign out_if.z_high = z_high_q;
endmodule

### sv/scz_checker.sv
// port-level checks of the spot z-extent scan
`timescale 1ns / 1ps
`include "sphere_cap_z_extent_scan_assert.svh"
module scz_checker import scz_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic                    hit_i,
  input logic signed [CRD_W-1:0] z_low_i,
  input logic signed [CRD_W-1:0] z_high_i
);
  `SCZ_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `SCZ_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i)
  `SCZ_ASSERT_NOW(a_miss_zero, out_valid_i && !hit_i, z_low_i == '0 && z_high_i == '0)
  `SCZ_ASSERT_NOW(a_hit_bound, out_valid_i && hit_i,
                  z_low_i <= 18'sd65536 && z_high_i <= 18'sd65536)
endmodule

bind sphere_cap_z_extent_scan scz_checker u_scz_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .hit_i       (out_if.hit),
  .z_low_i     (out_if.z_low),
  .z_high_i    (out_if.z_high)
);

### tb/scz_tb_ifs.sv
// note: the RTL interfaces live in sv/scz_ifs.sv; this file holds testbench helpers only
`timescale 1ns / 1ps
package scz_tb_pkg;
  import scz_pkg::*;

  typedef struct {
    logic signed [CRD_W-1:0] z_low;
    logic signed [CRD_W-1:0] z_high;
    logic                    hit;
  } extent_t;

  class extent_board;
    extent_t pending[$];
    int      errors;
    longint  cx, cy, cz, sz, rad, stp;

    function new();
      errors = 0;
      cx = 0; cy = 0; cz = 0; sz = 0; rad = 0; stp = 655;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CRD_W-1:0] d);
      case (idx)
        REG_SPHERE_CX: cx = longint'($signed(d));
        REG_SPHERE_CY: cy = longint'($signed(d));
        REG_SPHERE_CZ: cz = longint'($signed(d));
        REG_SCAN_CZ:   sz = longint'($signed(d));
        REG_RADIUS:    rad = longint'(d[RAD_W-1:0]);
        REG_STEP:      stp = longint'(d[RAD_W-1:0]);
        default: ;
      endcase
    endfunction

    function longint root_floor(longint v);
      longint lo, hi, mid;
      lo = 0; hi = 65537;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (mid * mid <= v) lo = mid; else hi = mid - 1;
      end
      return lo;
    endfunction

    function bit on_spot(longint y, longint z);
      longint one, r2, x, d2;
      one = 64'sd1 << 16;
      if (y > one || -y > one || z > one || -z > one) return 0;
      r2 = y * y + z * z;
      if (r2 > one * one) return 0;
      x = root_floor(one * one - r2);
      d2 = (x - cx) * (x - cx) + (y - cy) * (y - cy) + (z - cz) * (z - cz);
      return d2 <= rad * rad;
    endfunction

    function void note_row(logic signed [CRD_W-1:0] row_y);
      longint y, top, bot, z, zmax, zmin;
      bit got_max, got_min;
      extent_t e;
      y = row_y;
      top = sz + rad; bot = sz - rad;
      got_max = 0; got_min = 0; zmax = 0; zmin = 0;
      z = top;
      for (int n = 0; n < 256 && z > bot; n++) begin
        if (on_spot(y, z)) begin zmax = z; got_max = 1; break; end
        z -= stp;
      end
      z = bot;
      for (int n = 0; n < 256 && z < top; n++) begin
        if (on_spot(y, z)) begin zmin = z; got_min = 1; break; end
        z += stp;
      end
      if (!got_max || !got_min || zmin > 65536 || zmax > 65536) begin
        e.z_low = '0; e.z_high = '0; e.hit = 1'b0;
      end else begin
        e.z_low = zmin[CRD_W-1:0]; e.z_high = zmax[CRD_W-1:0]; e.hit = 1'b1;
      end
      pending.push_back(e);
    endfunction

    function void check_result(extent_t got);
      extent_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result z_low=%0d z_high=%0d hit=%0b", $time,
                 got.z_low, got.z_high, got.hit);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.z_low !== e.z_low) begin
        $display("%0t: z_low expected %0d actual %0d", $time, e.z_low, got.z_low);
        errors++;
      end
      if (got.z_high !== e.z_high) begin
        $display("%0t: z_high expected %0d actual %0d", $time, e.z_high, got.z_high);
        errors++;
      end
      if (got.hit !== e.hit) begin
        $display("%0t: hit expected %0b actual %0b", $time, e.hit, got.hit);
        errors++;
      end
    endfunction
  endclass
endpackage

### tb/testbench.sv
// testbench of the spot z-extent scan: directed and random rows, scoreboard check
`timescale 1ns / 1ps
module testbench;
  import scz_pkg::*;
  import scz_tb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  scz_cfg_if cfg_if ();
  scz_in_if  in_if ();
  scz_out_if out_if ();

  sphere_cap_z_extent_scan uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_if(cfg_if.sink), .in_if(in_if.sink), .out_if(out_if.source)
  );

  extent_board board = new();
  int send_idle = 0;   // percent
  int recv_stall = 0;  // percent
  int hold_off = 0;    // cycles of forced stall
  bit done = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    cfg_if.valid = 1'b0; cfg_if.index = '0; cfg_if.data = '0;
    in_if.valid = 1'b0; in_if.row_y = '0;
    out_if.ready = 1'b0;
  end

  // receiver
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk_i) begin
    extent_t r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      r.z_low = out_if.z_low; r.z_high = out_if.z_high; r.hit = out_if.hit;
      board.check_result(r);
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CRD_W-1:0] d);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1; cfg_if.index <= idx; cfg_if.data <= d;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    board.set_reg(idx, d);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // valid stays up between back-to-back rows; idle cycles and drain drop it
  task automatic send_row(logic signed [CRD_W-1:0] y);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1; in_if.row_y <= y;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    board.note_row(y);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (1200) @(negedge clk_i);
  endtask

  task automatic set_all(longint x, longint y, longint z, longint s, longint r, longint st);
    write_reg(REG_SPHERE_CX, x[CRD_W-1:0]);
    write_reg(REG_SPHERE_CY, y[CRD_W-1:0]);
    write_reg(REG_SPHERE_CZ, z[CRD_W-1:0]);
    write_reg(REG_SCAN_CZ, s[CRD_W-1:0]);
    write_reg(REG_RADIUS, r[CRD_W-1:0]);
    write_reg(REG_STEP, st[CRD_W-1:0]);
  endtask

  function automatic logic signed [CRD_W-1:0] rand_y();
    case ($urandom_range(9))
      0: return CRD_W'($urandom());
      1: return CRD_W'($urandom_range(65536));
      default: return CRD_W'($signed($urandom_range(131072)) - 65536);
    endcase
  endfunction

  // random spot center, radius and grid step, scan center near the spot center z
  task automatic random_config(int phase);
    longint x, y, z, r, st;
    r = $urandom_range(2000, 40000);
    y = $signed($urandom_range(100000)) - 50000;
    z = $signed($urandom_range(100000)) - 50000;
    x = $urandom_range(65536);
    st = (phase % 3 == 0) ? $urandom_range(1, 131071) : $urandom_range(200, 2000);
    set_all(x, y, z, z + $signed($urandom_range(200)) - 100, r, st);
  endtask

  initial begin
    logic signed [CRD_W-1:0] dir_y[$];
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // default registers: zero radius, always a miss
    send_row(18'sd0);
    send_row(-18'sd65536);
    drain();
    set_all(65536, 0, 0, 0, 16384, 655);
    dir_y = '{18'sd0, 18'sd65536, -18'sd65536, 18'sd8000, -18'sd8000, 18'sd131071,
              -18'sd131072, 18'sd1, -18'sd1, 18'sd16000, 18'sd16384, 18'sd30000};
    foreach (dir_y[i]) send_row(dir_y[i]);
    drain();
    // zero step, extreme registers
    set_all(-65536, 65536, -65536, -65536, 65536, 0);
    send_row(18'sd0); send_row(18'sd65535);
    drain();
    set_all(65536, -65536, 65536, 65536, 131071, 131071);
    send_row(18'sd0); send_row(-18'sd30000);
    drain();
    set_all(65536, 0, 0, 0, 0, 1);
    send_row(18'sd0);
    drain();
    // random phases with idling mixes
    for (int p = 0; p < 8; p++) begin
      send_idle = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 3) ? 33 : 55) : 0;
      recv_stall = (p % 4 == 2 || p % 4 == 3) ? ((p % 4 == 3) ? 33 : 55) : 0;
      random_config(p);
      // long enough for two worst-case rows, so the block fills and stalls input
      if (p == 4) hold_off = 30000;
      for (int i = 0; i < 60; i++) begin
        send_row(rand_y());
        if (p == 5 && i == 30) drain();
      end
      drain();
    end
    done = 1;
  end

  initial begin
    wait (done);
    if (board.errors == 0) $display("[sphere_cap_z_extent_scan] OK");
    else $display("[sphere_cap_z_extent_scan] ERROR");
    $finish;
  end

  initial begin
    #300ms;
    $display("[sphere_cap_z_extent_scan] ERROR");
    $finish;
  end
endmodule

### sim.f
+incdir+sv
sv/scz_pkg.sv
sv/scz_ifs.sv
sv/scz_cfg_regs.sv
sv/scz_sqrt.sv
sv/sphere_cap_z_extent_scan.sv
sv/scz_checker.sv
tb/scz_tb_ifs.sv
tb/testbench.sv
